/* rtl/core/vsc_pkg.sv */
`default_nettype none
package vsc_pkg;

  localparam int SEGMENT_LENGTH = 832;
  localparam int SAMPLE_BITS    = 12;

  localparam int POS_W  = $clog2(SEGMENT_LENGTH);
  localparam int TE_W   = SAMPLE_BITS + 2;
  localparam int INT_W  = 5;
  localparam int THR_W  = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;
  localparam int OUT_POS_W = 10;

  localparam logic signed [INT_W-1:0] INTEG_MIN = -5'sd16;
  localparam logic signed [INT_W-1:0] INTEG_MAX = 5'sd15;
  localparam logic [3:0] SYNC_PATTERN = 4'h9;
  localparam int INDEX_OFFSET = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [INT_W-1:0]       integ_t;
  typedef logic [POS_W-1:0]              pos_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCK_THRESHOLD   = 2'd0,
    CFG_UNLOCK_THRESHOLD = 2'd1,
    CFG_EMIT_UNLOCKED    = 2'd2
  } cfg_reg_t;

endpackage
`default_nettype wire

/* rtl/core/vsc_ram.sv */
`default_nettype none
module vsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/vsb_segment_sync_correlator.sv */
`default_nettype none
// Segment sync correlator.
// Input channel: in_valid / in_stall carrying in_symbol_in, one symbol per
// transaction. Result channel: out_valid / out_stall, exactly one result per
// input transaction, in order. Configuration: cfg_valid / cfg_ready with
// cfg_index (0 lock threshold, 1 unlock threshold, 2 emit unlocked) and
// cfg_data; cfg_ready is always high, writes to other indexes are dropped.
// The result of a symbol is registered in the output register at the edge that
// accepts it. Throughput is one symbol per cycle while in_stall is low; the
// integrator RAM is read one position ahead so its registered read is
// hidden, and the write-back goes to the position just processed.
// A stalled result holds; in_stall rises only while the output register is
// full and stalled, so a new symbol is taken in the same cycle the held
// result is drained.
// Reset (rst_n low, synchronous) clears control state; the integrators read
// as -16 throughout the first pass after reset, so no clearing pass is needed
// and symbols are accepted as soon as rst_n is released.
module vsb_segment_sync_correlator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [vsc_pkg::SAMPLE_BITS-1:0] in_symbol_in,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [vsc_pkg::SAMPLE_BITS-1:0] out_symbol_out,
  output logic [vsc_pkg::OUT_POS_W-1:0]         out_position,
  output logic                                  out_write_enable,
  output logic                                  out_segment_ready,
  output logic                                  out_segment_held,
  output logic                                  out_lock_state,
  output logic signed [vsc_pkg::TE_W-1:0]       out_timing_error,
  output logic                                  out_timing_update,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [vsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [vsc_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import vsc_pkg::*;

  logic signed [THR_W-1:0] lock_thr_r, unlock_thr_r;
  logic                    emit_unl_r;

  logic [3:0]  hist_r, hist_nxt;
  pos_t        pass_r, pass_nxt;
  pos_t        sym_r, sym_nxt;
  logic        first_pass_r, first_pass_nxt;
  logic        lock_r, lock_nxt;
  integ_t      best_val_r, best_val_nxt;
  pos_t        best_pos_r, best_pos_nxt;
  sample_t     rec_r [4];
  sample_t     rec_nxt [4];
  sample_t     bwin_r [4];
  sample_t     bwin_nxt [4];
  logic signed [TE_W-1:0] te_r, te_nxt;

  logic        accept;
  logic        pass_end;
  logic        take;
  integ_t      rd_data, base, integ_new;
  logic signed [INT_W:0] sum;
  sample_t     w [4];
  logic [1:0]  widx [4];
  logic        emit, last;

  logic        out_valid_r;
  sample_t     out_sym_r;
  pos_t        out_pos_r;
  logic        out_we_r, out_rdy_r, out_held_r, out_lock_r, out_upd_r;

  assign accept    = in_valid & ~in_stall;
  assign in_stall  = out_valid_r & out_stall;
  assign cfg_ready = 1'b1;
  assign pass_end  = (pass_r == POS_W'(SEGMENT_LENGTH - 1));

  vsc_ram #(.WIDTH(INT_W), .DEPTH(SEGMENT_LENGTH)) u_integ_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (pass_r),
    .wdata (integ_new),
    .raddr (pass_nxt),
    .rdata (rd_data)
  );

  always_comb begin
    hist_nxt       = hist_r;
    pass_nxt       = pass_r;
    sym_nxt        = sym_r;
    first_pass_nxt = first_pass_r;
    lock_nxt       = lock_r;
    best_val_nxt   = best_val_r;
    best_pos_nxt   = best_pos_r;
    te_nxt         = te_r;
    for (int k = 0; k < 4; k++) begin
      rec_nxt[k]  = rec_r[k];
      bwin_nxt[k] = bwin_r[k];
    end

    if (accept) begin
      rec_nxt[0] = in_symbol_in;
      for (int k = 1; k < 4; k++) begin
        rec_nxt[k] = rec_r[k-1];
      end
      hist_nxt = {~in_symbol_in[SAMPLE_BITS-1], hist_r[3:1]};
    end

    base = first_pass_r ? INTEG_MIN : rd_data;
    sum  = (INT_W+1)'(base) + ((hist_nxt == SYNC_PATTERN) ? (INT_W+1)'(2) : -(INT_W+1)'(1));
    if (sum < (INT_W+1)'(INTEG_MIN)) begin
      integ_new = INTEG_MIN;
    end else if (sum > (INT_W+1)'(INTEG_MAX)) begin
      integ_new = INTEG_MAX;
    end else begin
      integ_new = INT_W'(sum);
    end
    take = (pass_r == '0) || (integ_new > best_val_r);

    if (accept && take) begin
      best_val_nxt = integ_new;
      best_pos_nxt = pass_r;
      for (int k = 0; k < 4; k++) begin
        bwin_nxt[k] = rec_nxt[k];
      end
    end

    for (int k = 0; k < 4; k++) begin
      widx[k] = 2'(k) - 2'(best_pos_nxt) - 2'd1;
      if (POS_W'(k) <= best_pos_nxt) begin
        w[k] = bwin_nxt[k];
      end else begin
        w[k] = rec_nxt[widx[k]];
      end
    end

    if (accept) begin
      sym_nxt = (sym_r == POS_W'(SEGMENT_LENGTH - 1)) ? '0 : sym_r + 1'b1;
      pass_nxt = pass_r + 1'b1;
      if (pass_end) begin
        pass_nxt       = '0;
        first_pass_nxt = 1'b0;
        if (lock_r) begin
          lock_nxt = $signed({best_val_nxt[INT_W-1], best_val_nxt}) >= unlock_thr_r;
        end else begin
          lock_nxt = $signed({best_val_nxt[INT_W-1], best_val_nxt}) >= lock_thr_r;
        end
        te_nxt = -TE_W'(w[0]) - TE_W'(w[1]) + TE_W'(w[2]) + TE_W'(w[3]);
        if (best_pos_nxt <= POS_W'(INDEX_OFFSET - 1)) begin
          sym_nxt = POS_W'(INDEX_OFFSET - 1) - best_pos_nxt;
        end else begin
          sym_nxt = POS_W'(SEGMENT_LENGTH + INDEX_OFFSET - 1) - best_pos_nxt;
        end
      end
    end

    if (!rst_n) begin
      pass_nxt = '0;
    end

    emit = lock_nxt | emit_unl_r;
    last = (sym_nxt == POS_W'(SEGMENT_LENGTH - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_thr_r   <= THR_W'(5);
      unlock_thr_r <= THR_W'(2);
      emit_unl_r   <= 1'b0;
      hist_r       <= '0;
      pass_r       <= '0;
      sym_r        <= '0;
      first_pass_r <= 1'b1;
      lock_r       <= 1'b0;
      best_pos_r   <= '0;
      te_r         <= '0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        rec_r[k]  <= '0;
        bwin_r[k] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LOCK_THRESHOLD:   lock_thr_r   <= $signed(cfg_data[THR_W-1:0]);
          CFG_UNLOCK_THRESHOLD: unlock_thr_r <= $signed(cfg_data[THR_W-1:0]);
          CFG_EMIT_UNLOCKED:    emit_unl_r   <= cfg_data[0];
          default: ;
        endcase
      end
      hist_r       <= hist_nxt;
      pass_r       <= pass_nxt;
      sym_r        <= sym_nxt;
      first_pass_r <= first_pass_nxt;
      lock_r       <= lock_nxt;
      best_pos_r   <= best_pos_nxt;
      te_r         <= te_nxt;
      out_valid_r  <= accept | (out_valid_r & out_stall);
      for (int k = 0; k < 4; k++) begin
        rec_r[k]  <= rec_nxt[k];
        bwin_r[k] <= bwin_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    best_val_r <= best_val_nxt;
    if (accept) begin
      out_sym_r  <= in_symbol_in;
      out_pos_r  <= sym_nxt;
      out_we_r   <= emit;
      out_rdy_r  <= emit & last;
      out_held_r <= ~emit & last;
      out_lock_r <= lock_nxt;
      out_upd_r  <= pass_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_symbol_out    = out_sym_r;
  assign out_position      = OUT_POS_W'(out_pos_r);
  assign out_write_enable  = out_we_r;
  assign out_segment_ready = out_rdy_r;
  assign out_segment_held  = out_held_r;
  assign out_lock_state    = out_lock_r;
  assign out_timing_error  = te_r;
  assign out_timing_update = out_upd_r;

endmodule
`default_nettype wire

/* rtl/core/vsc_checker.sv */
`default_nettype none
module vsc_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [vsc_pkg::SAMPLE_BITS-1:0] out_symbol_out,
  input wire logic [vsc_pkg::OUT_POS_W-1:0]     out_position,
  input wire logic                              out_segment_ready,
  input wire logic                              out_segment_held
);
  import vsc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol_out) && $stable(out_position))
    else $error("stalled transaction changed");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_segment_ready && out_segment_held))
    else $error("segment ready and held together");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_segment_ready || out_segment_held)
      |-> out_position == OUT_POS_W'(SEGMENT_LENGTH - 1))
    else $error("segment end flagged away from last position");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");

endmodule

bind vsb_segment_sync_correlator vsc_checker u_vsc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_symbol_out    (out_symbol_out),
  .out_position      (out_position),
  .out_segment_ready (out_segment_ready),
  .out_segment_held  (out_segment_held)
);
`default_nettype wire

/* dv/vsb_segment_sync_correlator_tb.sv */
`timescale 1ns / 1ps

module vsb_segment_sync_correlator_tb;
  import vsc_pkg::*;

  localparam int DIR_COUNT   = 20;
  localparam int PHASE_COUNT = 6;
  localparam int PHASE_ITEMS = 325;
  localparam int SYNC_POS    = 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PRINT_LIMIT = 100;

  typedef enum {NOISE_FULL, NOISE_SPARSE, NOISE_NO_SYNC} noise_t;

  typedef struct packed {
    sample_t                symbol;
    logic [OUT_POS_W-1:0]   position;
    logic                   wr_en;
    logic                   seg_ready;
    logic                   seg_held;
    logic                   locked;
    logic signed [TE_W-1:0] terr;
    logic                   terr_upd;
  } seg_result_t;

  typedef struct packed {
    sample_t              sym;
    logic [OUT_POS_W-1:0] pos;
  } dir_row_t;

  typedef struct {
    logic signed [THR_W-1:0] lock_thr;
    logic signed [THR_W-1:0] unlock_thr;
    logic                    emit;
    noise_t                  noise;
  } phase_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  sample_t                in_symbol_in = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  sample_t                out_symbol_out;
  logic [OUT_POS_W-1:0]   out_position;
  logic                   out_write_enable;
  logic                   out_segment_ready;
  logic                   out_segment_held;
  logic                   out_lock_state;
  logic signed [TE_W-1:0] out_timing_error;
  logic                   out_timing_update;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DAT_W-1:0]   cfg_data = '0;

  vsb_segment_sync_correlator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_symbol_in      (in_symbol_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_symbol_out    (out_symbol_out),
    .out_position      (out_position),
    .out_write_enable  (out_write_enable),
    .out_segment_ready (out_segment_ready),
    .out_segment_held  (out_segment_held),
    .out_lock_state    (out_lock_state),
    .out_timing_error  (out_timing_error),
    .out_timing_update (out_timing_update),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #4 clk = ~clk;

  // directed symbols, all in the first pass after reset
  dir_row_t dir_rows [DIR_COUNT] = '{
    '{ 12'sd2047,        10'd1},
    '{ sample_t'(-2048), 10'd2},
    '{ 12'sd0,           10'd3},
    '{-12'sd1,           10'd4},
    '{-12'sd1,           10'd5},
    '{ 12'sd0,           10'd6},   // zero is non-negative: sync pattern completes
    '{ 12'sd1,           10'd7},
    '{ sample_t'(-2048), 10'd8},
    '{-12'sd2047,        10'd9},
    '{ 12'sd2047,        10'd10},  // second hit, ties with the first
    '{-12'sd1024,        10'd11},
    '{ 12'sd1024,        10'd12},
    '{ 12'sd1365,        10'd13},
    '{-12'sd1366,        10'd14},
    '{ 12'sd2046,        10'd15},
    '{-12'sd2047,        10'd16},
    '{ 12'sd1,           10'd17},
    '{ 12'sd0,           10'd18},
    '{-12'sd2,           10'd19},
    '{ 12'sd3,           10'd20}
  };

  phase_t phases [PHASE_COUNT] = '{
    '{ 6'sd16, -6'sd17, 1'b1, NOISE_FULL},
    '{-6'sd17,  6'sd16, 1'b0, NOISE_FULL},
    '{-6'sd14,  6'sd16, 1'b0, NOISE_SPARSE},
    '{ 6'sd16, -6'sd17, 1'b0, NOISE_NO_SYNC},
    '{ 6'sd5,   6'sd2,  1'b1, NOISE_NO_SYNC},
    '{-6'sd17,  6'sd16, 1'b0, NOISE_FULL}
  };

  // correlator state mirror
  logic [3:0]              sign_hist;
  integ_t                  integ_mem [SEGMENT_LENGTH];
  int                      pass_pos;
  int                      sym_pos;
  logic                    seg_locked;
  int                      best_val;
  int                      best_pos;
  sample_t                 recent [4];
  sample_t                 best_win [4];
  logic signed [TE_W-1:0]  terr_reg;
  logic signed [THR_W-1:0] lock_thr;
  logic signed [THR_W-1:0] unlock_thr;
  logic                    emit_unl;

  seg_result_t pending_results [$];

  int error_count  = 0;
  int result_count = 0;
  int symbol_count = 0;
  int update_count = 0;
  int lock_changes = 0;
  int cfg_writes   = 0;
  int cycle_count  = 0;
  int burst_left   = 0;

  function automatic void reset_correlator();
    sign_hist  = '0;
    foreach (integ_mem[i]) integ_mem[i] = INTEG_MIN;
    pass_pos   = 0;
    sym_pos    = 0;
    seg_locked = 1'b0;
    best_val   = 0;
    best_pos   = 0;
    foreach (recent[i]) recent[i] = '0;
    foreach (best_win[i]) best_win[i] = '0;
    terr_reg   = '0;
    lock_thr   = 6'sd5;
    unlock_thr = 6'sd2;
    emit_unl   = 1'b0;
  endfunction

  function automatic seg_result_t correlate_symbol(input sample_t s);
    seg_result_t r;
    int          acc;
    int          k;
    sample_t     win [4];
    logic        now_locked;
    logic        emit;
    recent[3] = recent[2];
    recent[2] = recent[1];
    recent[1] = recent[0];
    recent[0] = s;
    sign_hist = {~s[SAMPLE_BITS-1], sign_hist[3:1]};

    acc = int'(integ_mem[pass_pos]) + ((sign_hist == SYNC_PATTERN) ? 2 : -1);
    if (acc < int'(INTEG_MIN)) acc = int'(INTEG_MIN);
    if (acc > int'(INTEG_MAX)) acc = int'(INTEG_MAX);
    integ_mem[pass_pos] = integ_t'(acc);

    if (pass_pos == 0 || acc > best_val) begin
      best_val = acc;
      best_pos = pass_pos;
      best_win = recent;
    end

    sym_pos++;
    if (sym_pos >= SEGMENT_LENGTH) sym_pos = 0;
    pass_pos++;
    r.terr_upd = 1'b0;
    if (pass_pos >= SEGMENT_LENGTH) begin
      now_locked = seg_locked ? (best_val >= int'(unlock_thr)) : (best_val >= int'(lock_thr));
      if (now_locked != seg_locked) lock_changes++;
      seg_locked = now_locked;
      // window entries before position 0 wrap to the tail of this pass
      for (k = 0; k < 4; k++)
        win[k] = (k <= best_pos) ? best_win[k] : recent[(k - best_pos - 1) & 3];
      terr_reg = TE_W'(-int'(win[0]) - int'(win[1]) + int'(win[2]) + int'(win[3]));
      if (best_pos <= INDEX_OFFSET - 1)
        sym_pos = INDEX_OFFSET - 1 - best_pos;
      else
        sym_pos = SEGMENT_LENGTH + INDEX_OFFSET - 1 - best_pos;
      pass_pos   = 0;
      r.terr_upd = 1'b1;
      update_count++;
    end

    emit        = seg_locked || emit_unl;
    r.symbol    = s;
    r.position  = OUT_POS_W'(sym_pos);
    r.wr_en     = emit;
    r.seg_ready = emit && (sym_pos >= SEGMENT_LENGTH - 1);
    r.seg_held  = !emit && (sym_pos >= SEGMENT_LENGTH - 1);
    r.locked    = seg_locked;
    r.terr      = terr_reg;
    return r;
  endfunction

  // sync pattern (+ - - +) lands on SYNC_POS every pass; noise elsewhere
  function automatic sample_t pick_symbol(input noise_t noise);
    int   d;
    logic positive;
    d = (SYNC_POS - pass_pos + SEGMENT_LENGTH) % SEGMENT_LENGTH;
    if (d <= 3)
      positive = (d == 0 || d == 3);
    else begin
      case (noise)
        NOISE_SPARSE:  positive = ($urandom_range(0, 7) != 0);
        NOISE_NO_SYNC: positive = (sign_hist[3:1] == 3'b001) ? 1'b0 : 1'($urandom_range(0, 1));
        default:       return sample_t'($urandom);
      endcase
    end
    return positive ? sample_t'($urandom_range(0, 2047)) : sample_t'(-int'($urandom_range(1, 2048)));
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("MISMATCH: %s", msg);
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_count, name, got, want));
  endtask

  task automatic send_symbol(input sample_t s, input logic known, input seg_result_t typed);
    seg_result_t r;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_symbol_in <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    r = correlate_symbol(s);
    pending_results.push_back(known ? typed : r);
    symbol_count++;
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0)
      burst_left--;
    else begin
      gap = $urandom_range(1, 6);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 250) : $urandom_range(0, 12);
    end
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk) in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_LOCK_THRESHOLD:   lock_thr   = val[THR_W-1:0];
      CFG_UNLOCK_THRESHOLD: unlock_thr = val[THR_W-1:0];
      CFG_EMIT_UNLOCKED:    emit_unl   = val[0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    seg_result_t typed;
    int          ph;
    int          n;
    reset_correlator();
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      typed          = '0;
      typed.symbol   = dir_rows[i].sym;
      typed.position = dir_rows[i].pos;
      send_symbol(dir_rows[i].sym, 1'b1, typed);
      pace_sender();
    end

    // registers change only with the pipeline empty
    typed = '0;
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      drain_results();
      write_reg(CFG_LOCK_THRESHOLD, phases[ph].lock_thr);
      write_reg(CFG_UNLOCK_THRESHOLD, phases[ph].unlock_thr);
      write_reg(CFG_EMIT_UNLOCKED, {{(CFG_DAT_W-1){1'b0}}, phases[ph].emit});
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_symbol(pick_symbol(phases[ph].noise), 1'b0, typed);
        pace_sender();
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    while (pending_results.size() != 0) begin
      report_mismatch($sformatf("symbol %0d never produced a result",
                                symbol_count - pending_results.size() + 1));
      void'(pending_results.pop_front());
    end

    $display("Run: %0d symbols, %0d results, %0d register writes over %0d settings",
             symbol_count, result_count, cfg_writes, PHASE_COUNT + 1);
    $display("Run: %0d segment ends with timing update, %0d lock changes, %0d mismatches",
             update_count, lock_changes, error_count);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // one result transaction per accepted symbol, in order
  always @(posedge clk) begin : result_check
    seg_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      result_count++;
      if (pending_results.size() == 0)
        report_mismatch($sformatf("result %0d arrived with no symbol outstanding",
                                  result_count));
      else begin
        want = pending_results.pop_front();
        compare_field("symbol_out",    out_symbol_out,    want.symbol);
        compare_field("position",      out_position,      want.position);
        compare_field("write_enable",  out_write_enable,  want.wr_en);
        compare_field("segment_ready", out_segment_ready, want.seg_ready);
        compare_field("segment_held",  out_segment_held,  want.seg_held);
        compare_field("lock_state",    out_lock_state,    want.locked);
        compare_field("timing_error",  out_timing_error,  want.terr);
        compare_field("timing_update", out_timing_update, want.terr_upd);
      end
    end
  end

  initial begin : receiver
    int mode;
    int left;
    forever begin
      mode = $urandom_range(0, 3);
      left = $urandom_range(20, 160);
      repeat (left) begin
        @(negedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ((cycle_count % 7) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

/* sim.f */
rtl/core/vsc_pkg.sv
rtl/core/vsc_ram.sv
rtl/core/vsb_segment_sync_correlator.sv
rtl/core/vsc_checker.sv
dv/vsb_segment_sync_correlator_tb.sv
